// File: hdl/etl_pkg.sv
// Shared types and constants for the expression token lexer.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package etl_pkg;

    // Default width of offsets and run lengths inside the lexer
    localparam int POS_BITS_DEF = 16;

    // Output field widths
    localparam int KIND_BITS = 4;
    localparam int OUT_BITS  = 16;

    // Most tokens one character can cause: closed run, new token or run, end of input
    localparam int MAX_TOKENS = 3;

    // Token kinds
    localparam logic [KIND_BITS-1:0] K_EOF     = 4'd0;
    localparam logic [KIND_BITS-1:0] K_UNKNOWN = 4'd1;
    localparam logic [KIND_BITS-1:0] K_EQ      = 4'd2;
    localparam logic [KIND_BITS-1:0] K_PLUS    = 4'd3;
    localparam logic [KIND_BITS-1:0] K_MUL     = 4'd4;
    localparam logic [KIND_BITS-1:0] K_EOE     = 4'd5;
    localparam logic [KIND_BITS-1:0] K_LP      = 4'd6;
    localparam logic [KIND_BITS-1:0] K_RP      = 4'd7;
    localparam logic [KIND_BITS-1:0] K_INT     = 4'd8;
    localparam logic [KIND_BITS-1:0] K_ID      = 4'd9;

    // Character codes
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MUL   = 8'h2A;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [7:0] C_LP    = 8'h28;
    localparam logic [7:0] C_RP    = 8'h29;
    localparam logic [7:0] C_UNDER = 8'h5F;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_DIG0  = 8'h30;
    localparam logic [7:0] C_DIG9  = 8'h39;
    localparam logic [7:0] C_LA    = 8'h61;
    localparam logic [7:0] C_LZ    = 8'h7A;
    localparam logic [7:0] C_UA    = 8'h41;
    localparam logic [7:0] C_UZ    = 8'h5A;

    // One token as it leaves the block
    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [OUT_BITS-1:0]  start;
        logic [OUT_BITS-1:0]  length;
    } t_token;

    // All tokens caused by one character, packed from slot 0 up
    typedef struct packed {
        logic [1:0]                  count;
        t_token [MAX_TOKENS-1:0]     tok;
    } t_bundle;

endpackage

// File: hdl/etl_if.sv
// Valid/ready channel interfaces for the lexer's character input and token output.
// Depends on etl_pkg for field widths.

interface etl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_input;

    modport source (output valid, output ch, output end_of_input, input ready);
    modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface etl_out_if;
    logic                           valid;
    logic                           ready;
    logic [etl_pkg::KIND_BITS-1:0]  token_kind;
    logic [etl_pkg::OUT_BITS-1:0]   token_start;
    logic [etl_pkg::OUT_BITS-1:0]   token_length;
    logic                           last;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output last, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input last, output ready);
endinterface

// File: hdl/etl_core.sv
// Lexer state and per-character token logic: builds the bundle of tokens for one word.
// Depends on etl_pkg.
module etl_core #(
    parameter int POS_BITS = etl_pkg::POS_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_ch,
    input  logic             i_end_of_input,
    output etl_pkg::t_bundle o_bundle
);

    typedef enum logic [1:0] {
        RUN_NONE = 2'd0,
        RUN_INT  = 2'd1,
        RUN_ID   = 2'd2
    } t_run_mode;

    localparam int XW = (POS_BITS > etl_pkg::OUT_BITS) ? POS_BITS : etl_pkg::OUT_BITS;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    t_run_mode           r_mode, n_mode;
    logic [POS_BITS-1:0] r_start, n_start;
    logic [POS_BITS-1:0] r_len, n_len;
    logic [POS_BITS-1:0] r_pos, n_pos;

    logic                is_digit, is_head, is_body, is_space, taken, run_open;
    t_run_mode           mode_a;
    logic [POS_BITS-1:0] start_a, len_a;
    logic                v_old, v_single, v_final, v_mid;
    etl_pkg::t_token     t_old, t_single, t_final, t_mid, t_eof;
    logic [etl_pkg::KIND_BITS-1:0] single_kind;

    function automatic logic [etl_pkg::OUT_BITS-1:0] clip(input logic [POS_BITS-1:0] v);
        logic [XW-1:0] ext;
        ext = XW'(v);
        if (ext > XW'({etl_pkg::OUT_BITS{1'b1}})) begin
            return '1;
        end
        return ext[etl_pkg::OUT_BITS-1:0];
    endfunction

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + POS_BITS'(1);
    endfunction

    // Character classes
    always_comb begin
        is_digit = (i_ch >= etl_pkg::C_DIG0) && (i_ch <= etl_pkg::C_DIG9);
        is_head  = ((i_ch >= etl_pkg::C_LA) && (i_ch <= etl_pkg::C_LZ)) ||
                   ((i_ch >= etl_pkg::C_UA) && (i_ch <= etl_pkg::C_UZ)) ||
                   (i_ch == etl_pkg::C_UNDER);
        is_body  = is_head || is_digit;
        is_space = (i_ch == etl_pkg::C_SPACE) ||
                   ((i_ch >= etl_pkg::C_TAB) && (i_ch <= etl_pkg::C_CR));
    end

    // Single-character token kind
    always_comb begin
        case (i_ch)
            etl_pkg::C_EQ:   single_kind = etl_pkg::K_EQ;
            etl_pkg::C_PLUS: single_kind = etl_pkg::K_PLUS;
            etl_pkg::C_MUL:  single_kind = etl_pkg::K_MUL;
            etl_pkg::C_SEMI: single_kind = etl_pkg::K_EOE;
            etl_pkg::C_LP:   single_kind = etl_pkg::K_LP;
            etl_pkg::C_RP:   single_kind = etl_pkg::K_RP;
            default:         single_kind = etl_pkg::K_UNKNOWN;
        endcase
    end

    // Run handling and the tokens this character causes
    always_comb begin
        run_open = (r_mode == RUN_INT) || (r_mode == RUN_ID);
        taken    = ((r_mode == RUN_INT) && is_digit) || ((r_mode == RUN_ID) && is_body);

        // old run closed by a character outside it
        v_old        = !taken && run_open;
        t_old.kind   = (r_mode == RUN_INT) ? etl_pkg::K_INT : etl_pkg::K_ID;
        t_old.start  = clip(r_start);
        t_old.length = clip(r_len);

        // run state once this character is taken in
        v_single = 1'b0;
        if (taken) begin
            mode_a  = r_mode;
            start_a = r_start;
            len_a   = sat_inc(r_len);
        end else if (!is_space && is_digit) begin
            mode_a  = RUN_INT;
            start_a = r_pos;
            len_a   = POS_BITS'(1);
        end else if (!is_space && is_head) begin
            mode_a  = RUN_ID;
            start_a = r_pos;
            len_a   = POS_BITS'(1);
        end else begin
            mode_a   = RUN_NONE;
            start_a  = '0;
            len_a    = '0;
            v_single = !is_space;
        end
        t_single.kind   = single_kind;
        t_single.start  = clip(r_pos);
        t_single.length = etl_pkg::OUT_BITS'(1);

        n_pos = sat_inc(r_pos);

        // end of input closes whatever run is open, then reports eof
        v_final        = i_end_of_input && (mode_a != RUN_NONE);
        t_final.kind   = (mode_a == RUN_INT) ? etl_pkg::K_INT : etl_pkg::K_ID;
        t_final.start  = clip(start_a);
        t_final.length = clip(len_a);
        t_eof.kind     = etl_pkg::K_EOF;
        t_eof.start    = clip(n_pos);
        t_eof.length   = '0;

        // a single-character token and a final run never occur together
        v_mid = v_single || v_final;
        t_mid = v_single ? t_single : t_final;

        // pack from slot 0 upward
        o_bundle.tok[2] = t_eof;
        o_bundle.tok[1] = v_mid ? t_mid : t_eof;
        if (v_old) begin
            o_bundle.tok[0] = t_old;
            o_bundle.tok[1] = v_mid ? t_mid : t_eof;
        end else begin
            o_bundle.tok[0] = v_mid ? t_mid : t_eof;
            o_bundle.tok[1] = t_eof;
        end
        o_bundle.count = 2'(v_old) + 2'(v_mid) + 2'(i_end_of_input);

        // next state
        if (i_end_of_input) begin
            n_mode  = RUN_NONE;
            n_start = '0;
            n_len   = '0;
            n_pos   = '0;
        end else begin
            n_mode  = mode_a;
            n_start = start_a;
            n_len   = len_a;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RUN_NONE;
            r_start <= '0;
            r_len   <= '0;
            r_pos   <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_len   <= n_len;
            r_pos   <= n_pos;
        end
    end

endmodule

// File: hdl/etl_queue.sv
// Two-slot bundle buffer that hands tokens out one word at a time, marking the last of each.
// Depends on etl_pkg.
module etl_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  etl_pkg::t_bundle              i_bundle,
    output logic                          o_ready,
    output logic                          o_valid,
    input  logic                          i_ready,
    output etl_pkg::t_token               o_token,
    output logic                          o_last
);

    etl_pkg::t_bundle r_slot [2];
    logic [1:0]       r_full, n_full;
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_idx;

    logic             pop, pop_last;

    // Read side
    always_comb begin
        o_ready  = !r_full[r_wr_ptr];
        o_valid  = r_full[r_rd_ptr];
        o_token  = r_slot[r_rd_ptr].tok[r_idx];
        o_last   = (r_idx == r_slot[r_rd_ptr].count - 2'd1);
        pop      = o_valid && i_ready;
        pop_last = pop && o_last;
    end

    // Slot occupancy: a write and a final pop never hit the same slot
    always_comb begin
        n_full = r_full;
        if (i_wr) begin
            n_full[r_wr_ptr] = 1'b1;
        end
        if (pop_last) begin
            n_full[r_rd_ptr] = 1'b0;
        end
    end

    // Slot payload
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wr_ptr] <= i_bundle;
        end
    end

    // Slot flags and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full   <= '0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_full <= n_full;
            if (i_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop_last) begin
                r_rd_ptr <= !r_rd_ptr;
                r_idx    <= '0;
            end else if (pop) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

// File: hdl/expression_token_lexer.sv
// Expression token lexer: takes one character per word and gives tokens (kind, start
// offset, length) for = + * ; ( ), unknown characters, integer and identifier runs, and
// an end-of-input token after the flagged final character. A character is taken every
// cycle while the two-slot token buffer has a free slot; each character that causes
// tokens fills one slot, and the buffer drains one token per cycle while the output is
// ready, so the rate is one character per cycle as long as characters average at most
// one token each, and the output side sets it otherwise (a character causes up to three
// tokens). A character's tokens are registered in a buffer slot when it is taken.
// Depends on etl_pkg, etl_if, etl_core and etl_queue.
module expression_token_lexer #(
    parameter int POS_BITS = etl_pkg::POS_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    etl_in_if.sink        i_in,
    etl_out_if.source     o_out
);

    etl_pkg::t_bundle bundle;
    etl_pkg::t_token  token;
    logic             accept, q_ready, q_last, q_valid;

    assign accept    = i_in.valid && q_ready;
    assign i_in.ready = q_ready;

    // Lexer state and token building
    etl_core #(
        .POS_BITS(POS_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_ch          (i_in.ch),
        .i_end_of_input(i_in.end_of_input),
        .o_bundle      (bundle)
    );

    // Token buffer; words that cause no token write nothing
    etl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept && (bundle.count != 2'd0)),
        .i_bundle(bundle),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_ready (o_out.ready),
        .o_token (token),
        .o_last  (q_last)
    );

    assign o_out.valid        = q_valid;
    assign o_out.token_kind   = token.kind;
    assign o_out.token_start  = token.start;
    assign o_out.token_length = token.length;
    assign o_out.last         = q_last;

endmodule

// File: test/tb_top.sv
// Self-checking bench for the expression token lexer: a queue-fed character driver,
// a token monitor and a character-level token predictor. Depends on etl_pkg, etl_if and
// the lexer top level in hdl/.
`timescale 1ns / 100ps

module tb_top;

    localparam int  CYCLE_LIMIT = 500000;
    localparam int  RANDOM_WORDS = 180;
    localparam int  TAIL_CYCLES = 20;
    localparam int  GAP_MAX = 17;
    localparam logic [etl_pkg::OUT_BITS-1:0] POS_TOP = '1;

    // Whitespace codes not held in the package
    localparam logic [7:0] C_LF = 8'h0A;
    localparam logic [7:0] C_VT = 8'h0B;
    localparam logic [7:0] C_FF = 8'h0C;

    typedef enum logic [1:0] {RUN_NONE = 2'd0, RUN_INT = 2'd1, RUN_ID = 2'd2} t_run_kind;

    // One character word waiting to go in
    typedef struct {
        logic [7:0] ch;
        logic       fin;
        bit         quiet;   // no idling on either side while this word is current
        bit         drain;   // hold until every token due has come out
    } t_char_word;

    // One token the lexer owes us
    typedef struct packed {
        logic [etl_pkg::KIND_BITS-1:0] kind;
        logic [etl_pkg::OUT_BITS-1:0]  start;
        logic [etl_pkg::OUT_BITS-1:0]  length;
        logic                          last;
    } t_token_due;

    logic i_clk;
    logic i_rst_n;

    etl_in_if  chars_if ();
    etl_out_if toks_if ();

    expression_token_lexer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (chars_if),
        .o_out   (toks_if)
    );

    t_char_word char_words_q [$];
    t_token_due tokens_due [$];

    // Predictor state
    t_run_kind                    run_kind;
    logic [etl_pkg::OUT_BITS-1:0] run_first;
    logic [etl_pkg::OUT_BITS-1:0] run_len;
    logic [etl_pkg::OUT_BITS-1:0] next_pos;
    t_token_due                   burst_toks [0:etl_pkg::MAX_TOKENS-1];
    int                           burst_n;

    // Driver and monitor bookkeeping
    t_char_word cur_word;
    bit         loaded;
    bit         presenting;
    int         gap_left;
    int         stall_left;
    int         chars_taken;
    int         chars_seen;
    int         toks_taken;
    int         toks_seen;
    int         cycle_cnt;
    bit         failed;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit is_digit(logic [7:0] c);
        return c >= etl_pkg::C_DIG0 && c <= etl_pkg::C_DIG9;
    endfunction

    function automatic bit is_id_head(logic [7:0] c);
        return (c >= etl_pkg::C_LA && c <= etl_pkg::C_LZ) ||
               (c >= etl_pkg::C_UA && c <= etl_pkg::C_UZ) || c == etl_pkg::C_UNDER;
    endfunction

    function automatic bit is_id_body(logic [7:0] c);
        return is_id_head(c) || is_digit(c);
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == etl_pkg::C_SPACE || (c >= etl_pkg::C_TAB && c <= etl_pkg::C_CR);
    endfunction

    function automatic logic [etl_pkg::OUT_BITS-1:0] sat_inc(
        logic [etl_pkg::OUT_BITS-1:0] v);
        return (v == POS_TOP) ? v : v + 1'b1;
    endfunction

    function automatic logic [etl_pkg::KIND_BITS-1:0] punct_kind(logic [7:0] c);
        case (c)
            etl_pkg::C_EQ:   return etl_pkg::K_EQ;
            etl_pkg::C_PLUS: return etl_pkg::K_PLUS;
            etl_pkg::C_MUL:  return etl_pkg::K_MUL;
            etl_pkg::C_SEMI: return etl_pkg::K_EOE;
            etl_pkg::C_LP:   return etl_pkg::K_LP;
            etl_pkg::C_RP:   return etl_pkg::K_RP;
            default:         return etl_pkg::K_UNKNOWN;
        endcase
    endfunction

    task automatic note_token(input logic [etl_pkg::KIND_BITS-1:0] kind,
                              input logic [etl_pkg::OUT_BITS-1:0] start,
                              input logic [etl_pkg::OUT_BITS-1:0] length);
        burst_toks[burst_n] = '{kind: kind, start: start, length: length, last: 1'b0};
        burst_n++;
    endtask

    task automatic close_run();
        if (run_kind == RUN_INT) begin
            note_token(etl_pkg::K_INT, run_first, run_len);
        end else if (run_kind == RUN_ID) begin
            note_token(etl_pkg::K_ID, run_first, run_len);
        end
        run_kind  = RUN_NONE;
        run_first = '0;
        run_len   = '0;
    endtask

    task automatic clear_lexer();
        run_kind  = RUN_NONE;
        run_first = '0;
        run_len   = '0;
        next_pos  = '0;
    endtask

    // Work out the tokens one accepted character causes and queue them
    task automatic lex_char(input logic [7:0] c, input logic fin);
        bit taken;
        taken   = 1'b0;
        burst_n = 0;
        if (run_kind == RUN_INT && is_digit(c)) begin
            run_len = sat_inc(run_len);
            taken   = 1'b1;
        end else if (run_kind == RUN_ID && is_id_body(c)) begin
            run_len = sat_inc(run_len);
            taken   = 1'b1;
        end else begin
            close_run();
        end

        if (!taken) begin
            if (is_blank(c)) begin
                // skipped, position still moves
            end else if (is_digit(c)) begin
                run_kind  = RUN_INT;
                run_first = next_pos;
                run_len   = etl_pkg::OUT_BITS'(1);
            end else if (is_id_head(c)) begin
                run_kind  = RUN_ID;
                run_first = next_pos;
                run_len   = etl_pkg::OUT_BITS'(1);
            end else begin
                note_token(punct_kind(c), next_pos, etl_pkg::OUT_BITS'(1));
            end
        end

        next_pos = sat_inc(next_pos);

        if (fin) begin
            close_run();
            note_token(etl_pkg::K_EOF, next_pos, '0);
            clear_lexer();
        end

        for (int i = 0; i < burst_n; i++) begin
            if (i == burst_n - 1) begin
                burst_toks[i].last = 1'b1;
            end
            tokens_due.push_back(burst_toks[i]);
        end
    endtask

    // ---------------------------------------------------------------- checker

    task automatic check_token();
        t_token_due want;
        if (tokens_due.size() == 0) begin
            $error("token with nothing due: kind %0d start %0d length %0d last %0d",
                   toks_if.token_kind, toks_if.token_start, toks_if.token_length,
                   toks_if.last);
            failed = 1'b1;
        end else begin
            want = tokens_due.pop_front();
            if (toks_if.token_kind !== want.kind) begin
                $error("token_kind: expected %0d, got %0d", want.kind, toks_if.token_kind);
                failed = 1'b1;
            end
            if (toks_if.token_start !== want.start) begin
                $error("token_start: expected %0d, got %0d", want.start, toks_if.token_start);
                failed = 1'b1;
            end
            if (toks_if.token_length !== want.length) begin
                $error("token_length: expected %0d, got %0d", want.length,
                       toks_if.token_length);
                failed = 1'b1;
            end
            if (toks_if.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, toks_if.last);
                failed = 1'b1;
            end
        end
    endtask

    // Monitor: sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else if (i_rst_n) begin
            if (chars_if.valid && chars_if.ready) begin
                lex_char(chars_if.ch, chars_if.end_of_input);
                chars_taken++;
            end
            if (toks_if.valid === 1'b1 && toks_if.ready) begin
                toks_taken++;
                check_token();
            end
        end
    end

    // Driver: characters in and token ready, both changed at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            chars_if.valid <= 1'b0;
            toks_if.ready  <= 1'b0;
        end else begin
            if (presenting && chars_taken != chars_seen) begin
                presenting = 1'b0;
            end
            chars_seen = chars_taken;

            if (!presenting && !loaded && char_words_q.size() != 0) begin
                cur_word = char_words_q.pop_front();
                loaded   = 1'b1;
                gap_left = cur_word.quiet ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (!presenting && loaded) begin
                if (cur_word.drain && tokens_due.size() != 0) begin
                    // hold off until the token side has caught up
                end else if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    presenting = 1'b1;
                    loaded     = 1'b0;
                    chars_if.ch           <= cur_word.ch;
                    chars_if.end_of_input <= cur_word.fin;
                end
            end
            chars_if.valid <= presenting;

            // a fresh stall is drawn for every token taken
            if (toks_taken != toks_seen) begin
                toks_seen  = toks_taken;
                stall_left = cur_word.quiet ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (stall_left != 0) begin
                toks_if.ready <= 1'b0;
                stall_left--;
            end else begin
                toks_if.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic add_char(input logic [7:0] c, input logic fin,
                            input bit quiet = 1'b0, input bit drain = 1'b0);
        t_char_word w;
        w.ch    = c;
        w.fin   = fin;
        w.quiet = quiet;
        w.drain = drain;
        char_words_q.push_back(w);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_char(s[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // One random source: mostly well-formed expressions, some noise, a few unterminated
    task automatic add_random_source(input int src_no, inout int words);
        string      heads;
        string      bodies;
        string      digits;
        string      puncts;
        logic [7:0] blanks [6];
        logic [7:0] text [$];
        int         parts;
        bit         broken;
        bit         quiet;
        heads  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        bodies = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
        digits = "0123456789";
        puncts = "=+*;()";
        blanks = '{etl_pkg::C_SPACE, etl_pkg::C_TAB, C_LF, C_VT, C_FF, etl_pkg::C_CR};
        parts  = $urandom_range(1, 6);
        broken = ($urandom_range(0, 9) == 0);
        quiet  = (src_no % 6 == 5);
        for (int p = 0; p < parts; p++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    text.push_back(pick(heads));
                    repeat ($urandom_range(0, 5)) text.push_back(pick(bodies));
                end
                3, 4: begin
                    repeat ($urandom_range(1, 5)) text.push_back(pick(digits));
                end
                5, 6: text.push_back(pick(puncts));
                7: begin
                    repeat ($urandom_range(1, 2)) text.push_back(blanks[$urandom_range(0, 5)]);
                end
                default: text.push_back(8'($urandom_range(0, 255)));
            endcase
            if ($urandom_range(0, 1) == 0) begin
                text.push_back(blanks[$urandom_range(0, 5)]);
            end
        end
        foreach (text[i]) begin
            add_char(text[i], (i == text.size() - 1) && !broken, quiet,
                     (i == 0) && ($urandom_range(0, 14) == 0));
        end
        words += text.size();
    endtask

    task automatic build_stimulus();
        int words;
        int src_no;
        // All token kinds but * and ;, digit and letter extremes, zero and top bytes;
        // an identifier closed by ')' under the end flag gives three tokens
        add_text("Az_9=09+");
        add_char(8'h00, 1'b0);
        add_char(8'hFF, 1'b0);
        add_text("( a");
        add_char(etl_pkg::C_RP, 1'b1);
        // Five whitespace codes (all but space), then an identifier closed by the end flag
        add_char(etl_pkg::C_TAB, 1'b0);
        add_char(C_LF, 1'b0);
        add_char(C_VT, 1'b0);
        add_char(C_FF, 1'b0);
        add_char(etl_pkg::C_CR, 1'b0);
        add_text("*;Z");
        add_char("7", 1'b1);
        // Integer closed only by the end flag, and end on a blank alone
        add_char("5", 1'b1);
        add_char(etl_pkg::C_SPACE, 1'b1);

        words  = 0;
        src_no = 0;
        while (words < RANDOM_WORDS) begin
            add_random_source(src_no, words);
            src_no++;
        end
        // close whatever the last source left open, once the token side is empty
        add_char(etl_pkg::C_SPACE, 1'b1, 1'b0, 1'b1);
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n               = 1'b0;
        chars_if.valid        = 1'b0;
        chars_if.ch           = '0;
        chars_if.end_of_input = 1'b0;
        toks_if.ready         = 1'b0;
        loaded      = 1'b0;
        presenting  = 1'b0;
        gap_left    = 0;
        stall_left  = 0;
        chars_taken = 0;
        chars_seen  = 0;
        toks_taken  = 0;
        toks_seen   = 0;
        cycle_cnt   = 0;
        failed      = 1'b0;
        clear_lexer();

        build_stimulus();

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (char_words_q.size() != 0 || loaded || presenting) begin
            @(posedge i_clk);
        end
        while (tokens_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (!failed && tokens_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
